FILE: rtl/core/gcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GC window package
// Shared constants, character codes and register indexes of the GC window
// counter.
// ----------------------------------------------------------------------------
package gcw_pkg;

    localparam int COUNT_WIDTH_DEFAULT   = 24;
    localparam int FRACTION_BITS_DEFAULT = 16;

    localparam int CHAR_W     = 8;
    localparam int WSIZE_W    = 24;
    localparam int LEN_W      = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [WSIZE_W-1:0] SPAN_RESET = 24'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_SPAN      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORGIVING = 8'd1;

    localparam logic [CHAR_W-1:0] CHAR_G_UC = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_C_UC = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G_LC = 8'h67;
    localparam logic [CHAR_W-1:0] CHAR_C_LC = 8'h63;
    localparam logic [CHAR_W-1:0] CHAR_A_UC = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_T_UC = 8'h54;
    localparam logic [CHAR_W-1:0] CHAR_A_LC = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_T_LC = 8'h74;
    localparam logic [CHAR_W-1:0] CHAR_STOP = 8'h3E;

endpackage : gcw_pkg
`default_nettype wire

FILE: rtl/core/gcw_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GC window channel interfaces
// Base stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
interface gcw_base_if;
    import gcw_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] base_char;
    logic              sequence_end;

    modport source (output valid, output base_char, output sequence_end, input ready);
    modport sink   (input valid, input base_char, input sequence_end, output ready);
endinterface : gcw_base_if

interface gcw_result_if #(parameter int FRAC_W = 17);
    import gcw_pkg::*;
    logic             valid;
    logic             ready;
    logic [FRAC_W-1:0] gc_fraction;
    logic [FRAC_W-1:0] n_fraction;
    logic [LEN_W-1:0] window_length;
    logic             gc_invalid;

    modport source (output valid, output gc_fraction, output n_fraction,
                    output window_length, output gc_invalid, input ready);
    modport sink   (input valid, input gc_fraction, input n_fraction,
                    input window_length, input gc_invalid, output ready);
endinterface : gcw_result_if

interface gcw_cfg_if;
    import gcw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : gcw_cfg_if
`default_nettype wire

FILE: rtl/core/windowed_gc_content.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed GC content counter
// Each closed window is divided by the bit-serial dividers in the back end.
// Throughput: one base per cycle while the queue of four closed windows is
// not full; the back end takes a new window only once it has moved the
// result of the last one into the output register.
// Reset clears all window tallies, sets the window span to 1000 bases and
// forgiving_mode to 0.
// ----------------------------------------------------------------------------
module windowed_gc_content
    import gcw_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    gcw_base_if.sink      bases,
    gcw_cfg_if.sink       cfg,
    gcw_result_if.source  result
);

    localparam int JOB_W = 4 * COUNT_WIDTH + 1;

    logic             push, queue_full, queue_not_empty, pop;
    logic [JOB_W-1:0] front_job, queue_job;

    gcw_front #(.COUNT_WIDTH(COUNT_WIDTH), .JOB_W(JOB_W)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bases      (bases),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .job        (front_job)
    );

    gcw_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_job),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .pop_data  (queue_job)
    );

    gcw_back #(
        .COUNT_WIDTH   (COUNT_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .JOB_W         (JOB_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (queue_not_empty),
        .job       (queue_job),
        .pop       (pop),
        .result    (result)
    );

endmodule : windowed_gc_content
`default_nettype wire

FILE: rtl/core/gcw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GC window front end
// Takes one base per cycle while the queue is not full, classifies it, keeps
// the window tallies and queues a division request when a window closes.
// ----------------------------------------------------------------------------
module gcw_front
    import gcw_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT,
    parameter int JOB_W       = 4 * COUNT_WIDTH + 1
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    gcw_base_if.sink              bases,
    gcw_cfg_if.sink               cfg,
    input  wire logic             queue_full,
    output logic                  push,
    output logic [JOB_W-1:0]      job
);

    localparam int CW    = COUNT_WIDTH;
    localparam int CMP_W = (CW > WSIZE_W) ? CW : WSIZE_W;

    logic [WSIZE_W-1:0] span_reg;
    logic               forgiving_reg;
    logic [CW-1:0]      gc_reg, gc_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [CW-1:0]      counted_reg, counted_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic               stop_reg, stop_next;

    logic          is_gc, is_plain, is_stop, is_n;
    logic [CW-1:0] gc_upd, n_upd, counted_upd, pos_upd, plain;
    logic          closing, invalid, accept;

    assign cfg.ready   = 1'b1;
    assign bases.ready = !queue_full;
    assign accept      = bases.valid && bases.ready;

    always_comb
    begin
        is_gc    = 1'b0;
        is_plain = 1'b0;
        is_stop  = 1'b0;
        is_n     = 1'b0;
        unique case (bases.base_char) inside
            CHAR_G_UC, CHAR_C_UC, CHAR_G_LC, CHAR_C_LC: is_gc    = 1'b1;
            CHAR_A_UC, CHAR_T_UC, CHAR_A_LC, CHAR_T_LC: is_plain = 1'b1;
            CHAR_STOP:                                  is_stop  = 1'b1;
            default:                                    is_n     = 1'b1;
        endcase
    end

    always_comb
    begin
        pos_upd     = pos_reg + CW'(1);
        gc_upd      = gc_reg + CW'(!stop_reg && is_gc);
        n_upd       = n_reg + CW'(!stop_reg && is_n);
        counted_upd = counted_reg + CW'(!stop_reg && (is_gc || is_plain || is_n));
        closing     = bases.sequence_end || (CMP_W'(pos_upd) >= CMP_W'(span_reg));
        invalid     = (n_upd != '0) && !(forgiving_reg && (n_upd < counted_upd));
        plain       = (counted_upd >= n_upd) ? (counted_upd - n_upd) : '0;
        push        = accept && closing;
        job         = {invalid, plain, counted_upd, n_upd, gc_upd};

        gc_next      = gc_reg;
        n_next       = n_reg;
        counted_next = counted_reg;
        pos_next     = pos_reg;
        stop_next    = stop_reg;
        if (accept)
        begin
            if (closing)
            begin
                gc_next      = '0;
                n_next       = '0;
                counted_next = '0;
                pos_next     = '0;
                stop_next    = 1'b0;
            end
            else
            begin
                gc_next      = gc_upd;
                n_next       = n_upd;
                counted_next = counted_upd;
                pos_next     = pos_upd;
                stop_next    = stop_reg || is_stop;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg      <= SPAN_RESET;
            forgiving_reg <= 1'b0;
            gc_reg        <= '0;
            n_reg         <= '0;
            counted_reg   <= '0;
            pos_reg       <= '0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_SPAN)
                begin
                    span_reg <= WSIZE_W'(cfg.data);
                end
                else if (cfg.index == REG_FORGIVING)
                begin
                    forgiving_reg <= cfg.data[0];
                end
            end
            gc_reg      <= gc_next;
            n_reg       <= n_next;
            counted_reg <= counted_next;
            pos_reg     <= pos_next;
            stop_reg    <= stop_next;
        end
    end

endmodule : gcw_front
`default_nettype wire

FILE: rtl/core/gcw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GC window request queue
// Small register FIFO between the front end and the divider back end.
// ----------------------------------------------------------------------------
module gcw_queue
    import gcw_pkg::*;
#(
    parameter int WIDTH = 97,
    parameter int DEPTH = QUEUE_DEPTH
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule : gcw_queue
`default_nettype wire

FILE: rtl/core/gcw_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GC window divider
// Restoring divider, one quotient bit per cycle, that returns the low
// FRAC_BITS+1 bits of (num << FRAC_BITS) / den.
// ----------------------------------------------------------------------------
module gcw_div #(
    parameter int NUM_W     = 24,
    parameter int FRAC_BITS = 16
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [NUM_W-1:0] den,
    output logic                  busy,
    output logic [FRAC_BITS:0]    quotient
);

    localparam int STEPS  = NUM_W + FRAC_BITS;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic [STEPS-1:0]  dividend_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  den_reg;
    logic [FRAC_BITS:0] quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W:0]    trial;
    logic              fits;

    assign busy     = (step_reg != '0);
    assign quotient = quot_reg;
    assign trial    = {rem_reg, dividend_reg[STEPS-1]};
    assign fits     = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dividend_reg <= {num, {FRAC_BITS{1'b0}}};
            rem_reg      <= '0;
            den_reg      <= den;
            quot_reg     <= '0;
        end
        else if (busy)
        begin
            dividend_reg <= {dividend_reg[STEPS-2:0], 1'b0};
            rem_reg      <= fits ? NUM_W'(trial - {1'b0, den_reg}) : NUM_W'(trial);
            quot_reg     <= {quot_reg[FRAC_BITS-1:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(STEPS);
        end
        else if (busy)
        begin
            step_reg <= step_reg - STEP_W'(1);
        end
    end

endmodule : gcw_div
`default_nettype wire

FILE: rtl/core/gcw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// GC window back end
// Takes one request from the queue, runs both fractions on two dividers
// and holds the finished result in the output register.
// ----------------------------------------------------------------------------
module gcw_back
    import gcw_pkg::*;
#(
    parameter int COUNT_WIDTH   = COUNT_WIDTH_DEFAULT,
    parameter int FRACTION_BITS = FRACTION_BITS_DEFAULT,
    parameter int JOB_W         = 4 * COUNT_WIDTH + 1
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             job_valid,
    input  wire logic [JOB_W-1:0] job,
    output logic                  pop,
    gcw_result_if.source          result
);

    localparam int CW = COUNT_WIDTH;
    localparam int FW = FRACTION_BITS + 1;

    typedef enum logic {IDLE, RUN} state_t;

    state_t        state_reg;
    logic          out_valid_reg;
    logic [FW-1:0] gc_frac_reg, n_frac_reg;
    logic [LEN_W-1:0] length_reg, len_hold_reg;
    logic          invalid_reg, inv_hold_reg;
    logic          gc_zero_reg, n_zero_reg;

    logic [CW-1:0] job_gc, job_n, job_counted, job_plain;
    logic          job_invalid;
    logic          gc_busy, n_busy, finish;
    logic [FW-1:0] gc_quot, n_quot;

    assign {job_invalid, job_plain, job_counted, job_n, job_gc} = job;

    assign pop    = (state_reg == IDLE) && job_valid;
    assign finish = (state_reg == RUN) && !gc_busy && !n_busy
                    && (!out_valid_reg || result.ready);

    gcw_div #(.NUM_W(CW), .FRAC_BITS(FRACTION_BITS)) u_gc_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .num      (job_gc),
        .den      (job_plain),
        .busy     (gc_busy),
        .quotient (gc_quot)
    );

    gcw_div #(.NUM_W(CW), .FRAC_BITS(FRACTION_BITS)) u_n_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .num      (job_n),
        .den      (job_counted),
        .busy     (n_busy),
        .quotient (n_quot)
    );

    assign result.valid         = out_valid_reg;
    assign result.gc_fraction   = gc_frac_reg;
    assign result.n_fraction    = n_frac_reg;
    assign result.window_length = length_reg;
    assign result.gc_invalid    = invalid_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            len_hold_reg <= LEN_W'(job_counted);
            inv_hold_reg <= job_invalid;
            gc_zero_reg  <= job_invalid || (job_plain == '0);
            n_zero_reg   <= (job_counted == '0);
        end
        if (finish)
        begin
            gc_frac_reg <= gc_zero_reg ? '0 : gc_quot;
            n_frac_reg  <= n_zero_reg ? '0 : n_quot;
            length_reg  <= len_hold_reg;
            invalid_reg <= inv_hold_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= RUN;
                    end
                end
                RUN:
                begin
                    if (finish)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

endmodule : gcw_back
`default_nettype wire

FILE: tb/gcw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GC window checker
// Watches the base, configuration and result channels of the GC window
// counter. It keeps its own copy of the window tallies and registers, works
// out the result of every window that a base request closes, and compares
// each result request field by field with the oldest expected window.
// ----------------------------------------------------------------------------
module gcw_checker
    import gcw_pkg::*;
#(
    parameter int COUNT_W   = COUNT_WIDTH_DEFAULT,
    parameter int FRAC_BITS = FRACTION_BITS_DEFAULT
)(
    input  logic  clk,
    input  logic  rst_n,
    gcw_base_if   bases,
    gcw_cfg_if    cfg,
    gcw_result_if results,
    output int    pending,
    output int    failures
);

    localparam int FRAC_W = FRAC_BITS + 1;

    typedef struct packed {
        logic [FRAC_W-1:0] gc_fraction;
        logic [FRAC_W-1:0] n_fraction;
        logic [LEN_W-1:0]  window_length;
        logic              gc_invalid;
    } window_result_t;

    window_result_t       expected_windows[$];
    window_result_t       predicted;
    window_result_t       observed;
    logic [COUNT_W-1:0]   gc_seen;
    logic [COUNT_W-1:0]   n_count;
    logic [COUNT_W-1:0]   counted;
    logic [COUNT_W-1:0]   position;
    logic [COUNT_W-1:0]   plain_count;
    logic                 stop_flag;
    logic                 invalid;
    logic [WSIZE_W-1:0]   span_q;
    logic                 forgiving_q;
    int                   errors;

    function automatic logic [FRAC_W-1:0] fixed_ratio(input logic [COUNT_W-1:0] num,
                                                      input logic [COUNT_W-1:0] den);
        logic [63:0] scaled;
        if (den == '0)
            return '0;
        scaled = (64'(num) << FRAC_BITS) / 64'(den);
        return scaled[FRAC_W-1:0];
    endfunction

    task automatic check_field(input string field, input int exp_value, input int act_value);
        if (exp_value != act_value)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, exp_value, act_value);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_windows.delete();
            gc_seen     = '0;
            n_count     = '0;
            counted     = '0;
            position    = '0;
            stop_flag   = 1'b0;
            span_q      = SPAN_RESET;
            forgiving_q = 1'b0;
            errors      = 0;
            pending  <= 0;
            failures <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SPAN:      span_q      = cfg.data[WSIZE_W-1:0];
                    REG_FORGIVING: forgiving_q = cfg.data[0];
                    default: ;
                endcase
            end

            if (results.valid && results.ready)
            begin
                observed.gc_fraction   = results.gc_fraction;
                observed.n_fraction    = results.n_fraction;
                observed.window_length = results.window_length;
                observed.gc_invalid    = results.gc_invalid;
                if (expected_windows.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, observed);
                    errors++;
                end
                else
                begin
                    predicted = expected_windows.pop_front();
                    check_field("gc_fraction", int'(predicted.gc_fraction),
                                int'(observed.gc_fraction));
                    check_field("n_fraction", int'(predicted.n_fraction),
                                int'(observed.n_fraction));
                    check_field("window_length", int'(predicted.window_length),
                                int'(observed.window_length));
                    check_field("gc_invalid", int'(predicted.gc_invalid),
                                int'(observed.gc_invalid));
                end
            end

            if (bases.valid && bases.ready)
            begin
                position = position + COUNT_W'(1);
                if (!stop_flag)
                begin
                    case (bases.base_char)
                        CHAR_G_UC, CHAR_C_UC, CHAR_G_LC, CHAR_C_LC:
                        begin
                            gc_seen = gc_seen + COUNT_W'(1);
                            counted = counted + COUNT_W'(1);
                        end
                        CHAR_A_UC, CHAR_T_UC, CHAR_A_LC, CHAR_T_LC:
                            counted = counted + COUNT_W'(1);
                        CHAR_STOP:
                            stop_flag = 1'b1;
                        default:
                        begin
                            n_count = n_count + COUNT_W'(1);
                            counted = counted + COUNT_W'(1);
                        end
                    endcase
                end

                if (bases.sequence_end || (64'(position) >= 64'(span_q)))
                begin
                    invalid = (n_count != '0) && !(forgiving_q && n_count < counted);
                    plain_count = (counted >= n_count) ? counted - n_count : '0;
                    predicted.gc_fraction   = invalid ? '0 : fixed_ratio(gc_seen, plain_count);
                    predicted.n_fraction    = fixed_ratio(n_count, counted);
                    predicted.window_length = LEN_W'(counted);
                    predicted.gc_invalid    = invalid;
                    expected_windows.push_back(predicted);
                    gc_seen   = '0;
                    n_count   = '0;
                    counted   = '0;
                    position  = '0;
                    stop_flag = 1'b0;
                end
            end

            pending  <= expected_windows.size();
            failures <= errors;
        end
    end

endmodule : gcw_checker

FILE: tb/tb_windowed_gc_content.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed GC content counter testbench
// Drives short directed base sequences and then random phases of bases under
// several window sizes and both forgiving settings, with random gaps on the
// base channel and random stalls on the result channel. A checker beside the
// block predicts every window result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_windowed_gc_content;
    import gcw_pkg::*;

    localparam int LATENCY       = COUNT_WIDTH_DEFAULT + FRACTION_BITS_DEFAULT + 2;
    localparam int SETTLE_CYCLES = 2 * LATENCY;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 118;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hFF;

    localparam logic [CHAR_W-1:0] CHAR_N_UC     = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_N_LC     = 8'h6E;
    localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ALL_ONES = 8'hFF;
    localparam logic [CHAR_W-1:0] CHAR_HIGH     = 8'h80;
    localparam logic [CHAR_W-1:0] CHAR_QUESTION = 8'h3F;

    localparam logic [CHAR_W-1:0] GC_SET [4] = '{CHAR_G_UC, CHAR_C_UC, CHAR_G_LC, CHAR_C_LC};
    localparam logic [CHAR_W-1:0] AT_SET [4] = '{CHAR_A_UC, CHAR_T_UC, CHAR_A_LC, CHAR_T_LC};

    localparam logic [CHAR_W-1:0] PATTERN [23] = '{
        CHAR_G_UC, CHAR_C_UC, CHAR_G_LC, CHAR_C_LC,
        CHAR_A_UC, CHAR_T_UC, CHAR_A_LC, CHAR_T_LC,
        CHAR_G_UC, CHAR_NUL, CHAR_A_UC, CHAR_ALL_ONES,
        CHAR_STOP, CHAR_G_UC, CHAR_A_UC, CHAR_C_UC,
        CHAR_N_UC, CHAR_N_LC, CHAR_HIGH, CHAR_QUESTION,
        CHAR_C_UC, CHAR_STOP, CHAR_A_UC
    };

    logic clk;
    logic rst_n;
    int   pending;
    int   failures;
    int   cycle_count;
    bit   steady_source;
    bit   steady_sink;

    gcw_base_if   bases_ch();
    gcw_cfg_if    cfg_ch();
    gcw_result_if #(.FRAC_W(FRACTION_BITS_DEFAULT + 1)) result_ch();

    windowed_gc_content u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .bases  (bases_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    gcw_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .bases    (bases_ch),
        .cfg      (cfg_ch),
        .results  (result_ch),
        .pending  (pending),
        .failures (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CHAR_W-1:0] random_base();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 36)
            return GC_SET[$urandom_range(0, 3)];
        if (roll < 72)
            return AT_SET[$urandom_range(0, 3)];
        if (roll < 76)
            return CHAR_STOP;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    task automatic send_base(input logic [CHAR_W-1:0] base, input logic last);
        int gap;
        gap = steady_source ? 0 : idle_gap();
        repeat (gap)
        begin
            bases_ch.valid <= 1'b0;
            @(posedge clk);
        end
        bases_ch.valid        <= 1'b1;
        bases_ch.base_char    <= base;
        bases_ch.sequence_end <= last;
        @(posedge clk);
        while (!bases_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_window(input logic [WSIZE_W-1:0] size, input logic forgive);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = $urandom_range(0, 1) ? CFG_DATA_W'(forgive)
                                         : {CFG_DATA_W'($urandom) & ~CFG_DATA_W'(1)}
                                           | CFG_DATA_W'(forgive);
        write_register(REG_SPAN, CFG_DATA_W'(size));
        write_register(REG_FORGIVING, mode_word);
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        int run_left;
        logic level;
        run_left = 0;
        level    = 1'b1;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                if (steady_sink || $urandom_range(0, 2) != 0)
                begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 16);
                end
                else
                begin
                    level    = 1'b0;
                    run_left = idle_gap() + 1;
                end
            end
            run_left--;
            result_ch.ready <= level;
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_windowed_gc_content NOT OK");
        $finish;
    end

    initial
    begin
        logic [WSIZE_W-1:0] size;
        logic               forgive;
        int                 end_odds;

        rst_n                 <= 1'b0;
        bases_ch.valid        <= 1'b0;
        bases_ch.base_char    <= '0;
        bases_ch.sequence_end <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= '0;
        cfg_ch.data           <= '0;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: sequence ends close short windows.
        send_base(CHAR_G_UC, 1'b1);
        send_base(CHAR_STOP, 1'b1);
        bases_ch.valid <= 1'b0;
        wait_idle();

        set_window(WSIZE_W'(4), 1'b0);
        for (int i = 0; i < 23; i++)
            send_base(PATTERN[i], i == 22);
        bases_ch.valid <= 1'b0;
        wait_idle();

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            end_odds = 20;
            case (phase)
                0: begin size = WSIZE_W'(1); forgive = 1'b1; end
                1: begin size = '0; forgive = 1'b0; end
                2: begin size = '1; forgive = 1'b1; end_odds = 10; end
                3: begin size = WSIZE_W'(2); forgive = 1'b0; end
                4: begin size = WSIZE_W'($urandom_range(3, 12)); forgive = 1'b1; end
                5: begin size = WSIZE_W'($urandom_range(3, 40)); forgive = 1'b0; end
                6: begin size = WSIZE_W'($urandom_range(1, 8)); forgive = 1'($urandom_range(0, 1)); end
                default:
                begin
                    size    = WSIZE_W'($urandom_range(1, 16777215));
                    forgive = 1'($urandom_range(0, 1));
                    end_odds = 12;
                end
            endcase
            if (phase == 3)
                write_register(REG_UNUSED, CFG_DATA_W'($urandom));
            set_window(size, forgive);
            steady_source = ($urandom_range(0, 3) == 0);
            steady_sink   = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_base(random_base(),
                          (i == PHASE_ITEMS - 1) || ($urandom_range(1, end_odds) == 1));
            bases_ch.valid <= 1'b0;
            wait_idle();
        end

        if (failures == 0)
            $display("tb_windowed_gc_content OK");
        else
            $display("tb_windowed_gc_content NOT OK");
        $finish;
    end

endmodule : tb_windowed_gc_content
